>>> rtl/lz77d_pkg.sv
// Types and constants shared by the LZ77 token stream decoder.
`timescale 1ns / 1ps

package lz77d_pkg;

    // Decoder phase: what the next input byte means
    typedef enum logic [1:0] {
        PH_TOKEN   = 2'd0,
        PH_LITERAL = 2'd1,
        PH_MATCH   = 2'd2
    } t_phase;

    localparam logic [7:0] TOKEN_END   = 8'h00;
    localparam logic [3:0] NIBBLE_ZERO = 4'h0;
    localparam int         OFFSET_W    = 12;
    localparam int         LEN_W       = 5;
    localparam int         LEFT_W      = 4;

    // Bit positions inside the result tuser field
    localparam int USER_EOS = 0;
    localparam int USER_BAD = 1;

endpackage

>>> rtl/lz77_token_stream_decoder_top.sv
// Top level of the LZ77 token stream decoder with its history ring memory.
//
//  channel  | dir | tdata          | tlast        | tuser
//  ---------+-----+----------------+--------------+-----------------------------
//  s_axis   | in  | in_byte [7:0]  | -            | -
//  m_axis   | out | out_byte [7:0] | last_of_run  | [0] end_of_stream, [1] bad_offset
//
// Token and literal bytes are accepted while the output register is free. The
// second byte of a match starts a copy of 2..16 bytes: the ring has a single
// registered read port and yields one history byte per cycle. Input is held
// off while a copy runs. Reset (synchronous, active low) clears phase, write
// pointer and valids, not the ring or copy source pointer. A stalled output
// holds the copy engine in place, and the memory read data holds with it.
`timescale 1ns / 1ps

module lz77_token_stream_decoder_top
    import lz77d_pkg::*;
#(
    parameter int RING_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request in
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    // request out
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // last_of_run
    output logic [1:0] o_m_axis_tuser    // [0] end_of_stream, [1] bad_offset
);

    localparam int           PW        = $clog2(RING_DEPTH);
    localparam logic [PW:0]  DEPTH_EXT = (PW + 1)'(RING_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(RING_DEPTH - 1);

    // Ring pointer increment with wrap at the ring depth
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == LAST_PTR) ? '0 : p + 1'b1;
        return q;
    endfunction

    // History ring
    logic [7:0] r_ring [RING_DEPTH];
    logic [7:0] r_mem_q;

    // Control state
    t_phase            r_phase, n_phase;
    logic [LEFT_W-1:0] r_lit_left, n_lit_left;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [3:0]        r_off_hi, n_off_hi;
    logic [PW-1:0]     r_wp, n_wp;
    logic              r_busy, n_busy;
    logic [PW-1:0]     r_src, n_src;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_rd_valid, n_rd_valid;
    logic              r_rd_last, n_rd_last;
    logic              r_fwd_hit;
    logic [7:0]        r_fwd_data;

    // Output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic [1:0] r_out_user, n_out_user;

    // Memory port controls
    logic          wr_en, rd_en;
    logic [PW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    logic                in_acc, out_free, move, issue;
    logic [OFFSET_W-1:0] offset;
    logic [PW:0]         diff;
    logic [PW-1:0]       src_start;
    logic [LEN_W-1:0]    len_m1;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_busy && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign move            = r_rd_valid && out_free;
    assign issue           = r_busy && (r_left != '0) && (!r_rd_valid || move);

    // Ring read data, with the byte written in the read cycle forwarded
    assign rd_data = r_fwd_hit ? r_fwd_data : r_mem_q;

    // Copy source: offset bytes behind the write pointer, wrapped
    assign offset    = {r_off_hi, i_s_axis_tdata};
    assign diff      = {1'b0, r_wp} - (PW + 1)'(offset);
    assign src_start = diff[PW] ? PW'(diff + DEPTH_EXT) : PW'(diff);
    assign len_m1    = r_len - 1'b1;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (in_acc) begin
            case (r_phase)
                PH_TOKEN: begin
                    if (i_s_axis_tdata == TOKEN_END) begin
                        n_phase = PH_TOKEN;
                    end else if (i_s_axis_tdata[7:4] == NIBBLE_ZERO) begin
                        n_phase = PH_LITERAL;
                    end else begin
                        n_phase = PH_MATCH;
                    end
                end
                PH_LITERAL: begin
                    if (r_lit_left == LEFT_W'(1)) begin
                        n_phase = PH_TOKEN;
                    end
                end
                PH_MATCH: n_phase = PH_TOKEN;
                default:  n_phase = PH_TOKEN;
            endcase
        end
    end

    // Datapath, ring port control and output register loading
    always_comb begin
        n_lit_left  = r_lit_left;
        n_len       = r_len;
        n_off_hi    = r_off_hi;
        n_wp        = r_wp;
        n_busy      = r_busy;
        n_src       = r_src;
        n_left      = r_left;
        n_rd_valid  = r_rd_valid;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;
        wr_en       = 1'b0;
        wr_addr     = r_wp;
        wr_data     = i_s_axis_tdata;
        rd_en       = 1'b0;
        rd_addr     = r_src;

        if (in_acc) begin
            case (r_phase)
                PH_TOKEN: begin
                    if (i_s_axis_tdata == TOKEN_END) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                        n_out_last  = 1'b1;
                        n_out_user  = 2'b01 << USER_EOS;
                    end else if (i_s_axis_tdata[7:4] == NIBBLE_ZERO) begin
                        n_lit_left = i_s_axis_tdata[3:0];
                    end else begin
                        n_len    = LEN_W'(i_s_axis_tdata[7:4]) + 1'b1;
                        n_off_hi = i_s_axis_tdata[3:0];
                    end
                end
                PH_LITERAL: begin
                    wr_en       = 1'b1;
                    n_wp        = ptr_inc(r_wp);
                    n_lit_left  = r_lit_left - 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = i_s_axis_tdata;
                    n_out_last  = 1'b1;
                    n_out_user  = '0;
                end
                PH_MATCH: begin
                    if (offset == '0) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = '0;
                        n_out_last  = 1'b1;
                        n_out_user  = 2'b01 << USER_BAD;
                    end else begin
                        // first read of the copy goes out now
                        rd_en      = 1'b1;
                        rd_addr    = src_start;
                        n_src      = ptr_inc(src_start);
                        n_left     = LEFT_W'(len_m1);
                        n_rd_valid = 1'b1;
                        n_rd_last  = (len_m1 == '0);
                        n_busy     = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // Copied byte leaves the read stage: emit and write back
        if (move) begin
            wr_en       = 1'b1;
            wr_data     = rd_data;
            n_wp        = ptr_inc(r_wp);
            n_out_valid = 1'b1;
            n_out_byte  = rd_data;
            n_out_last  = r_rd_last;
            n_out_user  = '0;
            n_rd_valid  = 1'b0;
            if (r_rd_last) begin
                n_busy = 1'b0;
            end
        end

        // Next copy read
        if (issue) begin
            rd_en      = 1'b1;
            rd_addr    = r_src;
            n_src      = ptr_inc(r_src);
            n_left     = r_left - 1'b1;
            n_rd_valid = 1'b1;
            n_rd_last  = (r_left == LEFT_W'(1));
        end
    end

    // Ring memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q    <= r_ring[rd_addr];
            r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= wr_data;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TOKEN;
            r_lit_left  <= '0;
            r_len       <= '0;
            r_off_hi    <= '0;
            r_wp        <= '0;
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_lit_left  <= n_lit_left;
            r_len       <= n_len;
            r_off_hi    <= n_off_hi;
            r_wp        <= n_wp;
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_rd_last  <= n_rd_last;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

endmodule

>>> verif/testbench.sv
// Self-checking stream testbench for the LZ77 token stream decoder top level.
`timescale 1ns / 1ps

module testbench;
    import lz77d_pkg::*;

    localparam int RING_DEPTH     = 4096;
    localparam int MAX_OFFSET     = RING_DEPTH - 1;
    localparam int MAX_COPY       = 16;
    localparam int RANDOM_ITEMS   = 70;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    // One decoded byte or marker as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eos;
        logic       bad;
    } t_out_beat;

    // One compressed byte waiting to be sent; drain holds it until all output is in
    typedef struct {
        logic [7:0] data;
        bit         drain;
    } t_in_req;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       m_ready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic [1:0] o_m_axis_tuser;

    lz77_token_stream_decoder_top #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Stimulus and expected output
    t_in_req   byte_q[$];
    t_out_beat decoded_q[$];

    // Decoder shadow state
    logic [7:0]          hist_shadow [0:RING_DEPTH-1];
    t_phase              dec_phase = PH_TOKEN;
    logic [LEFT_W-1:0]   lit_left  = '0;
    logic [LEN_W-1:0]    pend_len  = '0;
    logic [3:0]          off_hi    = '0;
    logic [OFFSET_W-1:0] wr_ptr    = '0;

    // Bookkeeping
    int gen_produced = 0;
    int gen_items    = 0;
    int accepted_in  = 0;
    int results_seen = 0;
    int n_literal    = 0;
    int n_copied     = 0;
    int n_end        = 0;
    int n_bad        = 0;
    int mismatches   = 0;
    int hold_start   = 32'h7fff_ffff;
    int tx_gap       = 0;
    int rx_hold      = 0;
    int idle_cycles  = 0;
    bit tx_burst     = 1'b0;
    bit rx_burst     = 1'b0;
    bit hold_started = 1'b0;
    t_in_req tx_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Shadow decoder: one compressed byte in, its decoded beats queued
    task automatic decode_byte(input logic [7:0] b);
        logic [OFFSET_W-1:0] match_off;
        logic [OFFSET_W-1:0] src;
        int                  len;
        int                  i;
        t_out_beat           beat;
        case (dec_phase)
            PH_LITERAL: begin
                hist_shadow[wr_ptr] = b;
                wr_ptr   = wr_ptr + 1'b1;
                lit_left = lit_left - 1'b1;
                if (lit_left == '0) dec_phase = PH_TOKEN;
                beat = '{data: b, last: 1'b1, eos: 1'b0, bad: 1'b0};
                decoded_q.push_back(beat);
                n_literal++;
            end
            PH_MATCH: begin
                match_off = {off_hi, b};
                dec_phase = PH_TOKEN;
                if (match_off == '0) begin
                    beat = '{data: 8'h00, last: 1'b1, eos: 1'b0, bad: 1'b1};
                    decoded_q.push_back(beat);
                    n_bad++;
                end else begin
                    len = (pend_len > MAX_COPY) ? MAX_COPY : int'(pend_len);
                    src = wr_ptr - match_off;
                    for (i = 0; i < len; i++) begin
                        beat.data = hist_shadow[src];
                        beat.last = (i == len - 1);
                        beat.eos  = 1'b0;
                        beat.bad  = 1'b0;
                        hist_shadow[wr_ptr] = beat.data;
                        decoded_q.push_back(beat);
                        wr_ptr = wr_ptr + 1'b1;
                        src    = src + 1'b1;
                    end
                    n_copied += len;
                end
            end
            default: begin
                dec_phase = PH_TOKEN;
                if (b == TOKEN_END) begin
                    beat = '{data: 8'h00, last: 1'b1, eos: 1'b1, bad: 1'b0};
                    decoded_q.push_back(beat);
                    n_end++;
                end else if (b[7:4] == NIBBLE_ZERO) begin
                    lit_left  = b[3:0];
                    dec_phase = PH_LITERAL;
                end else begin
                    pend_len  = b[7:4] + 1'b1;
                    off_hi    = b[3:0];
                    dec_phase = PH_MATCH;
                end
            end
        endcase
    endtask

    // Stimulus builders
    task automatic push_byte(input logic [7:0] b, input bit drain);
        t_in_req req;
        req.data  = b;
        req.drain = drain;
        byte_q.push_back(req);
        gen_items++;
    endtask

    // Literal run with random content
    task automatic add_literals(input int n, input bit drain);
        int k;
        push_byte({NIBBLE_ZERO, 4'(n)}, drain);
        for (k = 0; k < n; k++) push_byte(8'($urandom_range(0, 255)), 1'b0);
        gen_produced += n;
    endtask

    // Match of len bytes from back bytes behind; caller keeps back within written history
    task automatic add_match(input int len, input int back);
        push_byte({4'(len - 1), 4'(back >> 8)}, 1'b0);
        push_byte(8'(back), 1'b0);
        gen_produced += len;
    endtask

    function automatic int safe_dist();
        int top;
        top = (gen_produced < MAX_OFFSET) ? gen_produced : MAX_OFFSET;
        if ($urandom_range(0, 1)) return $urandom_range(1, (top < 20) ? top : 20);
        return $urandom_range(1, top);
    endfunction

    // Stimulus plan
    initial begin
        int k;
        int roll;
        int rand_from;

        // End token before any history exists
        push_byte(TOKEN_END, 1'b0);
        // Longest literal run, extreme byte values first
        push_byte({NIBBLE_ZERO, 4'hf}, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'haa, 1'b0);
        for (k = 0; k < 11; k++) push_byte(8'($urandom_range(0, 255)), 1'b0);
        gen_produced = 15;
        // Shortest literal run
        push_byte({NIBBLE_ZERO, 4'h1}, 1'b0);
        push_byte(8'hff, 1'b0);
        gen_produced++;
        // Shortest and longest copies; offset one overlaps every byte
        add_match(2, 1);
        add_match(MAX_COPY, 1);
        add_match(MAX_COPY, 16);
        // Offset zero on the longest and shortest length
        push_byte(8'hf0, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h10, 1'b0);
        push_byte(8'h00, 1'b0);

        // Random mix of well-formed tokens with some end markers and zero offsets
        rand_from  = gen_items;
        hold_start = gen_items + 40;
        while (gen_items - rand_from < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (gen_items - rand_from == 0 || (gen_items - rand_from > 60 &&
                                               gen_items - rand_from < 64)) begin
                // drained start: sender waits for all output first
                add_literals($urandom_range(1, 15), 1'b1);
            end else if (roll < 55) begin
                add_match($urandom_range(2, MAX_COPY), safe_dist());
            end else if (roll < 82) begin
                add_literals($urandom_range(1, 15), 1'b0);
            end else if (roll < 91) begin
                push_byte(TOKEN_END, 1'b0);
            end else begin
                push_byte({4'($urandom_range(1, 15)), NIBBLE_ZERO}, 1'b0);
                push_byte(8'h00, 1'b0);
            end
        end
    end

    // Reset, then wait for everything to drain and judge the run
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (byte_q.size() != 0 || s_valid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (MAX_COPY + 24) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            $display("tb: %0d expected beats never arrived", decoded_q.size());
            mismatches += decoded_q.size();
        end
        $display("tb summary: %0d compressed bytes in, %0d beats out", accepted_in,
                 results_seen);
        $display("tb summary: %0d literals, %0d copied bytes, %0d end markers, %0d bad offsets",
                 n_literal, n_copied, n_end, n_bad);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Driver: offers queued bytes with random gaps, shadows each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                decode_byte(s_data);
                accepted_in <= accepted_in + 1;
            end
            if ($urandom_range(0, 63) == 0) tx_burst <= !tx_burst;
            if (!s_valid || o_s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (byte_q.size() != 0 &&
                             (!byte_q[0].drain || decoded_q.size() == 0)) begin
                    tx_req  = byte_q.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= tx_req.data;
                    tx_gap  <= tx_burst ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted beat and drives ready with random stalls
    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                got.data = o_m_axis_tdata;
                got.last = o_m_axis_tlast;
                got.eos  = o_m_axis_tuser[USER_EOS];
                got.bad  = o_m_axis_tuser[USER_BAD];
                results_seen <= results_seen + 1;
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("tb: unexpected beat data=%02h last=%b eos=%b bad=%b",
                                 got.data, got.last, got.eos, got.bad);
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"tb: beat %0d mismatch: expected data=%02h last=%b ",
                                      "eos=%b bad=%b, got data=%02h last=%b eos=%b bad=%b"},
                                     results_seen, want.data, want.last, want.eos, want.bad,
                                     got.data, got.last, got.eos, got.bad);
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) rx_burst <= !rx_burst;
            // one long hold so the decoder backs up into its input
            if (!hold_started && accepted_in >= hold_start) begin
                hold_started <= 1'b1;
                rx_hold      <= LONG_HOLD;
                m_ready      <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= 1'b0;
            end else if (rx_burst || $urandom_range(0, 9) < 7) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_hold <= pick_gap();
            end
        end
    end

    // Watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: no progress for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
